FILE: rtl/dbcw_pkg.sv
// ----------------------------------------------------------------------------
// dbcw_pkg
// Types and constants shared by the delay-based congestion window core.
// ----------------------------------------------------------------------------
package dbcw_pkg;

  localparam int FIELD_W = 32;   // width of rtt / window fields on the ports
  localparam int THR_W   = 16;   // width of the threshold registers
  localparam int SEG_W   = 16;   // width of the acked segment count

  localparam logic [THR_W-1:0] ALPHA_RST = 16'd2;
  localparam logic [THR_W-1:0] BETA_RST  = 16'd4;
  localparam logic [THR_W-1:0] GAMMA_RST = 16'd1;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_ACK      = 2'd1,
    CMD_ACK_SRTT = 2'd2,
    CMD_LOSS     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RG_SAMPLE  = 3'd0,
    RG_NO_DATA = 3'd1,
    RG_SS_GROW = 3'd2,
    RG_SS_EXIT = 3'd3,
    RG_UP      = 3'd4,
    RG_HOLD    = 3'd5,
    RG_DOWN    = 3'd6,
    RG_LOSS    = 3'd7
  } region_t;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_GAMMA = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FIELD_W-1:0] rtt_sample;
    logic [SEG_W-1:0]   ack_segs;
    logic               slow_start;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] window;
    logic [FIELD_W-1:0] threshold;
    logic [FIELD_W-1:0] min_rtt;
    logic [2:0]         region;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [THR_W-1:0] value;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_delta;
    logic load_mul;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/dbcw_chan_if.sv
// ----------------------------------------------------------------------------
// dbcw_chan_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface dbcw_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dbcw_ctrl.sv
// ----------------------------------------------------------------------------
// dbcw_ctrl
// Sequencer: accept, delta, multiply, bit-serial divide, commit.
// ----------------------------------------------------------------------------
module dbcw_ctrl import dbcw_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.load_delta = 1'b1;
        state_next     = status.need_div ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.load_mul = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result beat
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/dbcw_datapath.sv
// ----------------------------------------------------------------------------
// dbcw_datapath
// Connection state, thresholds, queue estimate multiply/divide, result reg.
// ----------------------------------------------------------------------------
module dbcw_datapath import dbcw_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  req_t       req_data,
  input  logic       cfg_valid,
  input  cfg_t       cfg_data,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp_data
);

  localparam int VB  = VALUE_BITS;
  localparam int VB1 = VALUE_BITS + 1;
  localparam logic [VB-1:0] VAL_ONES = '1;
  localparam logic [VB-1:0] VAL_TWO  = VB'(2);
  localparam logic [VB-1:0] SS_RST   = VAL_ONES >> 1;

  logic [THR_W-1:0] alpha, beta, gamma;
  logic [VB-1:0]    base_rtt_min, last_rtt, cong_window, ss_threshold;
  cmd_t             cmd_q;
  logic [SEG_W-1:0] acked_q;
  logic             ss_q;
  logic [VB-1:0]    delta;
  logic             no_data;
  logic [VB-1:0]    div_hi, div_lo;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RST;
      beta  <= BETA_RST;
      gamma <= GAMMA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_data.index)
        REG_ALPHA: alpha <= cfg_data.value;
        REG_BETA:  beta  <= cfg_data.value;
        REG_GAMMA: gamma <= cfg_data.value;
        default: ;
      endcase
    end
  end

  // ---------------- sample on accept ----------------
  logic [FIELD_W-1:0] srtt_full;
  logic [VB-1:0]      sample_v;
  logic               take;

  assign srtt_full = req_data.rtt_sample >> 3;
  assign sample_v  = (req_data.cmd == CMD_ACK_SRTT) ? srtt_full[VB-1:0]
                                                    : req_data.rtt_sample[VB-1:0];
  assign take = cmd.accept && sample_v != '0 &&
                (req_data.cmd == CMD_SAMPLE || req_data.cmd == CMD_ACK_SRTT);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_rtt_min <= VAL_ONES;
      last_rtt     <= '0;
    end else if (take) begin
      last_rtt <= sample_v;
      if (sample_v < base_rtt_min) base_rtt_min <= sample_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q   <= cmd_t'(req_data.cmd);
      acked_q <= req_data.ack_segs;
      ss_q    <= req_data.slow_start;
    end
  end

  // ---------------- queue estimate ----------------
  logic no_data_now;
  logic need_div;
  assign no_data_now = (base_rtt_min == '0) || (base_rtt_min == VAL_ONES) ||
                       (last_rtt == '0);
  assign need_div    = (cmd_q == CMD_ACK || cmd_q == CMD_ACK_SRTT) && !no_data_now;

  logic [2*VB-1:0] prod;
  logic [VB:0]     trial, trial_sub;
  logic            trial_ge;

  assign prod      = (2*VB)'(cong_window) * (2*VB)'(delta);
  assign trial     = {div_hi, div_lo[VB-1]};
  assign trial_sub = trial - {1'b0, last_rtt};
  assign trial_ge  = trial >= {1'b0, last_rtt};

  always_ff @(posedge clk) begin
    if (cmd.load_delta) begin
      delta   <= (last_rtt > base_rtt_min) ? last_rtt - base_rtt_min : '0;
      no_data <= no_data_now;
    end
    if (cmd.load_mul) begin
      {div_hi, div_lo} <= prod;
    end else if (cmd.div_step) begin
      // restoring divide; high half starts below the divisor since delta < last_rtt
      div_hi <= trial_ge ? trial_sub[VB-1:0] : trial[VB-1:0];
      div_lo <= {div_lo[VB-2:0], trial_ge};
    end
  end

  // ---------------- window update ----------------
  logic [VB-1:0]    diff, w_next, ss_next, half, grown;
  logic [VB:0]      grow_sum;
  logic [SEG_W-1:0] eff_acked, grow_by;
  logic             eff_ss;
  region_t          region;

  assign diff      = div_lo;
  assign eff_acked = (cmd_q == CMD_ACK_SRTT) ? SEG_W'(1) : acked_q;
  assign eff_ss    = (cmd_q == CMD_ACK) && ss_q;
  assign grow_by   = (eff_ss || cong_window < ss_threshold) ? eff_acked : SEG_W'(1);
  assign grow_sum  = {1'b0, cong_window} + VB1'(grow_by);
  assign grown     = grow_sum[VB] ? VAL_ONES : grow_sum[VB-1:0];
  assign half      = ((cong_window >> 1) < VAL_TWO) ? VAL_TWO : (cong_window >> 1);

  always_comb begin
    w_next  = cong_window;
    ss_next = ss_threshold;
    region  = RG_SAMPLE;
    case (cmd_q) inside
      CMD_LOSS: begin
        w_next  = half;
        ss_next = half;
        region  = RG_LOSS;
      end
      CMD_ACK, CMD_ACK_SRTT: begin
        if (no_data) begin
          region = RG_NO_DATA;
        end else begin
          if (eff_ss) begin
            if (diff > VB'(gamma)) begin
              ss_next = cong_window;
              region  = RG_SS_EXIT;
            end else begin
              w_next = grown;
              region = RG_SS_GROW;
            end
          end else if (diff < VB'(alpha)) begin
            w_next = grown;
            region = RG_UP;
          end else if (diff > VB'(beta)) begin
            w_next = (cong_window != '0) ? cong_window - VB'(1) : '0;
            region = RG_DOWN;
          end else begin
            region = RG_HOLD;
          end
          if (w_next < VAL_TWO) w_next = VAL_TWO;
        end
      end
      default: region = RG_SAMPLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cong_window  <= VAL_TWO;
      ss_threshold <= SS_RST;
    end else if (cmd.commit) begin
      cong_window  <= w_next;
      ss_threshold <= ss_next;
    end
  end

  // ---------------- result register ----------------
  assign status = '{need_div: need_div, out_free: !rsp_valid || rsp_ready};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.window    <= FIELD_W'(w_next);
      rsp_data.threshold <= FIELD_W'(ss_next);
      rsp_data.min_rtt   <= FIELD_W'(base_rtt_min);
      rsp_data.region    <= region;
    end
  end

endmodule

FILE: rtl/delay_based_congestion_window_core.sv
// ----------------------------------------------------------------------------
// delay_based_congestion_window_core
// Delay-based congestion window for one connection.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                   beat when
//   req      in   cmd, rtt_sample, ack_segs, slow_start        req.valid & req.ready
//   rsp      out  window, threshold, min_rtt, region           rsp.valid & rsp.ready
//   cfg      in   index, value (alpha, beta, gamma)            cfg.valid & cfg.ready
//
// ACK beats (cmd 1, 2) with rtt data on hand pass through delta, multiply
// and the one-bit-per-cycle divider for the queue estimate before commit.
// Sample, loss and no-data ACK beats go from delta straight to commit.
// One event is in flight at a time.
// The result sits in an output register; the next event is accepted while it
// waits, and the block stalls before commit only if that register is still full.
// rst is synchronous; cfg is always ready.
// ----------------------------------------------------------------------------
module delay_based_congestion_window_core import dbcw_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  dbcw_chan_if.sink   req,
  dbcw_chan_if.source rsp,
  dbcw_chan_if.sink   cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  dbcw_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dbcw_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule

FILE: rtl/dbcw_checker.sv
// ----------------------------------------------------------------------------
// dbcw_checker
// Port-level checks on the result channel of the core.
// ----------------------------------------------------------------------------
module dbcw_checker import dbcw_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_floor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.window >= FIELD_W'(2))
    else $error("window below floor");

  a_loss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.region == RG_LOSS |-> rsp_data.window == rsp_data.threshold)
    else $error("loss did not set threshold to window");

  a_ss_exit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.region == RG_SS_EXIT |->
      rsp_data.threshold == rsp_data.window)
    else $error("slow start exit did not latch window");

endmodule

bind delay_based_congestion_window_core dbcw_checker u_dbcw_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
